// File: design/pnz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnz_pkg: shared types and constants
// Item kinds, configuration register indexes, lattice cell bundle and the
// back-end status word used by the noise evaluator.
// ----------------------------------------------------------------------------
package pnz_pkg;

  localparam int unsigned PERM_SIZE = 256;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned OFF_W     = 24;
  localparam int unsigned OUT_W     = 18;
  localparam int unsigned OUT_FRAC  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_DEPTH = 16;
  localparam int unsigned CNT_W     = $clog2(OUT_DEPTH + 1);

  // input word kinds
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X = 2'd0,
    CFG_OFFSET_Y = 2'd1,
    CFG_OFFSET_Z = 2'd2
  } cfg_idx_e;

  // wrapped lattice cell per axis
  typedef struct packed {
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    logic [IDX_W-1:0] z;
  } cell_t;

  // back-end occupancy
  typedef struct packed {
    logic [CNT_W-1:0] credits;
    logic [CNT_W-1:0] out_count;
  } back_stat_t;

endpackage

// File: design/pnz_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnz_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module pnz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: design/pnz_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnz_front: input side
// Accepts words, adds the axis offsets, splits each axis into cell and
// fraction, and queues the result for the back end.
// ----------------------------------------------------------------------------
module pnz_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  logic                                  kind_i,
  input  logic [pnz_pkg::IDX_W-1:0]             table_index_i,
  input  logic [pnz_pkg::IDX_W-1:0]             table_value_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]    x_coord_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]    y_coord_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]    z_coord_i,
  input  logic [pnz_pkg::OFF_W-1:0]             offset_x_i,
  input  logic [pnz_pkg::OFF_W-1:0]             offset_y_i,
  input  logic [pnz_pkg::OFF_W-1:0]             offset_z_i,
  output logic                                  item_valid_o,
  input  logic                                  item_ready_i,
  output pnz_pkg::kind_e                        item_kind_o,
  output logic [pnz_pkg::IDX_W-1:0]             item_tidx_o,
  output logic [pnz_pkg::IDX_W-1:0]             item_tval_o,
  output pnz_pkg::cell_t                        item_cell_o,
  output logic [2:0][FRAC_BITS-1:0]             item_frac_o
);
  import pnz_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = 2;
  localparam int unsigned SUM_W = COORD_W + 1;

  typedef struct packed {
    kind_e                    kind;
    logic [IDX_W-1:0]         tidx;
    logic [IDX_W-1:0]         tval;
    cell_t                    lat;
    logic [2:0][FRAC_BITS-1:0] frac;
  } entry_t;

  logic signed [COORD_W-1:0] coord [3];
  logic [OFF_W-1:0]          off   [3];
  logic signed [SUM_W-1:0]   sum   [3];
  entry_t                    wr_entry;
  entry_t                    mem_q [DEPTH];
  logic [PTR_W-1:0]          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]            cnt_q, cnt_d;
  logic                      push_ok, pop_ok;

  assign coord[0] = x_coord_i;
  assign coord[1] = y_coord_i;
  assign coord[2] = z_coord_i;
  assign off[0]   = offset_x_i;
  assign off[1]   = offset_y_i;
  assign off[2]   = offset_z_i;

  // offset add and axis split
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUM_W'(coord[i]) + $signed(SUM_W'(off[i]));
    end
    wr_entry.kind   = kind_e'(kind_i);
    wr_entry.tidx   = table_index_i;
    wr_entry.tval   = table_value_i;
    wr_entry.lat.x  = sum[0][FRAC_BITS +: IDX_W];
    wr_entry.lat.y  = sum[1][FRAC_BITS +: IDX_W];
    wr_entry.lat.z  = sum[2][FRAC_BITS +: IDX_W];
    for (int i = 0; i < 3; i++) begin
      wr_entry.frac[i] = sum[i][FRAC_BITS-1:0];
    end
  end

  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign push_ok = push_i && !full_o;
  assign pop_ok  = item_valid_o && item_ready_i;

  // queue pointers
  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_ok ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (PTR_W+1)'(push_ok) - (PTR_W+1)'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wr_entry;
    end
  end

  // head of queue
  assign item_valid_o = (cnt_q != '0);
  assign item_kind_o  = mem_q[rd_ptr_q].kind;
  assign item_tidx_o  = mem_q[rd_ptr_q].tidx;
  assign item_tval_o  = mem_q[rd_ptr_q].tval;
  assign item_cell_o  = mem_q[rd_ptr_q].lat;
  assign item_frac_o  = mem_q[rd_ptr_q].frac;

endmodule

// File: design/pnz_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnz_back: evaluation pipeline
// Eight stages: three hash levels over replicated permutation RAMs, the
// fade polynomial, corner dot products, trilinear blend, then the result
// queue. Loads write each RAM copy as they pass its stage.
// ----------------------------------------------------------------------------
module pnz_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 item_valid_i,
  output logic                                 item_ready_o,
  input  pnz_pkg::kind_e                       item_kind_i,
  input  logic [pnz_pkg::IDX_W-1:0]            item_tidx_i,
  input  logic [pnz_pkg::IDX_W-1:0]            item_tval_i,
  input  pnz_pkg::cell_t                       item_cell_i,
  input  logic [2:0][FRAC_BITS-1:0]            item_frac_i,
  output logic                                 empty_o,
  input  logic                                 pop_i,
  output logic signed [pnz_pkg::OUT_W-1:0]     noise_value_o,
  output pnz_pkg::back_stat_t                  stat_o
);
  import pnz_pkg::*;

  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned QW     = F + 6;
  localparam int unsigned LW     = F + 3;
  localparam int unsigned TW     = F + 2;
  localparam int unsigned DW     = F + 2;
  localparam int unsigned RW     = LW + OUT_FRAC;
  localparam int unsigned SH_R   = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam int unsigned SH_L   = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
  localparam int unsigned NS     = 8;
  localparam int unsigned NRAM   = 7;
  localparam int unsigned OPTR_W = $clog2(OUT_DEPTH);

  localparam logic signed [QW-1:0] FIFTEEN_Q = QW'(15) << F;
  localparam logic signed [QW-1:0] TEN_Q     = QW'(10) << F;
  localparam logic signed [DW-1:0] ONE_D     = DW'(1) << F;
  localparam logic signed [RW-1:0] SAT_MAX   = RW'(131071);
  localparam logic signed [RW-1:0] SAT_MIN   = -RW'(131072);

  // gradient components per code: x, y, z masks of +1 and -1
  localparam logic [2:0][15:0] GRAD_POS = {16'h2330, 16'h5503, 16'h1055};
  localparam logic [2:0][15:0] GRAD_NEG = {16'h8CC0, 16'hAA0C, 16'h40AA};

  typedef struct packed {
    kind_e                     kind;
    logic [IDX_W-1:0]          tidx;
    logic [IDX_W-1:0]          tval;
    cell_t                     lat;
    logic [2:0][F-1:0]         frac;
    logic [2:0][QW-1:0]        fq;
    logic [7:0][LW-1:0]        dot;
    logic [3:0][LW-1:0]        lx;
    logic [1:0][LW-1:0]        ly;
    logic [LW-1:0]             r;
  } stage_t;

  function automatic logic [QW-1:0] fade_mul(input logic [F-1:0] f, input logic [QW-1:0] q);
    logic signed [F+QW:0] prod;
    logic signed [F+QW:0] shf;
    prod = $signed({1'b0, f}) * $signed(q);
    shf  = prod >>> F;
    return shf[QW-1:0];
  endfunction

  function automatic logic [LW-1:0] lerp(input logic [TW-1:0] t, input logic [LW-1:0] a,
                                         input logic [LW-1:0] b);
    logic signed [LW:0]    diff;
    logic signed [LW+TW:0] prod;
    logic signed [LW+TW:0] shf;
    logic signed [LW-1:0]  res;
    diff = (LW+1)'($signed(b)) - (LW+1)'($signed(a));
    prod = $signed(t) * diff;
    shf  = prod >>> F;
    res  = $signed(a) + $signed(shf[LW-1:0]);
    return res;
  endfunction

  function automatic logic [LW-1:0] grad_dot(input logic [3:0] h,
                                             input logic [2:0][DW-1:0] d);
    logic signed [LW-1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      if (GRAD_POS[i][h]) begin
        acc = acc + LW'($signed(d[i]));
      end else if (GRAD_NEG[i][h]) begin
        acc = acc - LW'($signed(d[i]));
      end
    end
    return acc;
  endfunction

  logic [NS-1:0]              vld_q, vld_d;
  stage_t                     pay_q [NS];
  stage_t                     pay_d [NS];
  logic                       issue, issue_eval;
  logic                       ram_we    [NRAM];
  logic [IDX_W-1:0]           ram_waddr [NRAM];
  logic [IDX_W-1:0]           ram_wdata [NRAM];
  logic [1:0][IDX_W-1:0]      raddr     [NRAM];
  logic [1:0][IDX_W-1:0]      rdata     [NRAM];
  logic [IDX_W-1:0]           a1, b1, a2, a3, b2, b3;
  logic [2:0][DW-1:0]         dvec;
  logic signed [DW-1:0]       d0 [3];
  logic signed [DW-1:0]       d1 [3];
  logic [3:0]                 hash;
  logic signed [RW-1:0]       r_ext, r_scl;
  logic [OUT_W-1:0]           r_sat;
  logic                       out_push, out_pop;
  logic [OUT_W-1:0]           out_mem_q [OUT_DEPTH];
  logic [OPTR_W-1:0]          out_wptr_q, out_rptr_q;
  logic [CNT_W-1:0]           out_cnt_q, out_cnt_d, credit_q, credit_d;

  // issue: loads always pass, evaluations need room in the result queue
  assign item_ready_o = (item_kind_i == KIND_LOAD) || (credit_q < CNT_W'(OUT_DEPTH));
  assign issue        = item_valid_i && item_ready_o;
  assign issue_eval   = issue && (item_kind_i == KIND_EVAL);

  // permutation RAM copies: 0 at stage 0, 1..2 at stage 1, 3..6 at stage 2
  for (genvar g = 0; g < NRAM; g++) begin : g_ram
    localparam int unsigned STG = (g == 0) ? 0 : ((g < 3) ? 1 : 2);
    assign ram_we[g]    = vld_q[STG] && (pay_q[STG].kind == KIND_LOAD);
    assign ram_waddr[g] = pay_q[STG].tidx;
    assign ram_wdata[g] = pay_q[STG].tval;
    pnz_ram #(.WIDTH(IDX_W), .DEPTH(PERM_SIZE)) u_ram (
      .clk_i     (clk_i),
      .we_i      (ram_we[g]),
      .waddr_i   (ram_waddr[g]),
      .wdata_i   (ram_wdata[g]),
      .raddr_a_i (raddr[g][0]),
      .raddr_b_i (raddr[g][1]),
      .rdata_a_o (rdata[g][0]),
      .rdata_b_o (rdata[g][1])
    );
  end

  // hash address chain
  always_comb begin
    raddr[0][0] = pay_q[0].lat.x;
    raddr[0][1] = pay_q[0].lat.x + IDX_W'(1);
    a1 = rdata[0][0] + pay_q[1].lat.y;
    b1 = rdata[0][1] + pay_q[1].lat.y;
    raddr[1][0] = a1;
    raddr[1][1] = a1 + IDX_W'(1);
    raddr[2][0] = b1;
    raddr[2][1] = b1 + IDX_W'(1);
    a2 = rdata[1][0] + pay_q[2].lat.z;
    a3 = rdata[1][1] + pay_q[2].lat.z;
    b2 = rdata[2][0] + pay_q[2].lat.z;
    b3 = rdata[2][1] + pay_q[2].lat.z;
    raddr[3][0] = a2;
    raddr[3][1] = a2 + IDX_W'(1);
    raddr[4][0] = b2;
    raddr[4][1] = b2 + IDX_W'(1);
    raddr[5][0] = a3;
    raddr[5][1] = a3 + IDX_W'(1);
    raddr[6][0] = b3;
    raddr[6][1] = b3 + IDX_W'(1);
  end

  // pipeline datapath
  always_comb begin
    pay_d[0]      = '0;
    pay_d[0].kind = item_kind_i;
    pay_d[0].tidx = item_tidx_i;
    pay_d[0].tval = item_tval_i;
    pay_d[0].lat  = item_cell_i;
    pay_d[0].frac = item_frac_i;
    // fade seed: 6f - 15
    for (int i = 0; i < 3; i++) begin
      pay_d[0].fq[i] = (QW'(item_frac_i[i]) << 2) + (QW'(item_frac_i[i]) << 1) - FIFTEEN_Q;
    end
    vld_d[0] = issue;
    for (int k = 1; k < NS; k++) begin
      pay_d[k] = pay_q[k-1];
      vld_d[k] = vld_q[k-1];
    end
    // fade steps, one multiply per stage
    for (int i = 0; i < 3; i++) begin
      pay_d[1].fq[i] = fade_mul(pay_q[0].frac[i], pay_q[0].fq[i]) + TEN_Q;
      pay_d[2].fq[i] = fade_mul(pay_q[1].frac[i], pay_q[1].fq[i]);
      pay_d[3].fq[i] = fade_mul(pay_q[2].frac[i], pay_q[2].fq[i]);
      pay_d[4].fq[i] = fade_mul(pay_q[3].frac[i], pay_q[3].fq[i]);
    end
    // corner dot products at stage 3
    for (int i = 0; i < 3; i++) begin
      d0[i] = DW'(pay_q[3].frac[i]);
      d1[i] = DW'(pay_q[3].frac[i]) - ONE_D;
    end
    dvec = '0;
    hash = '0;
    for (int k = 0; k < 8; k++) begin
      dvec[0] = k[0] ? d1[0] : d0[0];
      dvec[1] = k[1] ? d1[1] : d0[1];
      dvec[2] = k[2] ? d1[2] : d0[2];
      hash    = rdata[3 + k[1:0]][k[2]][3:0];
      pay_d[4].dot[k] = grad_dot(hash, dvec);
    end
    // blend along x, y, z
    for (int j = 0; j < 4; j++) begin
      pay_d[5].lx[j] = lerp(pay_q[4].fq[0][TW-1:0], pay_q[4].dot[2*j], pay_q[4].dot[2*j+1]);
    end
    for (int j = 0; j < 2; j++) begin
      pay_d[6].ly[j] = lerp(pay_q[5].fq[1][TW-1:0], pay_q[5].lx[2*j], pay_q[5].lx[2*j+1]);
    end
    pay_d[7].r = lerp(pay_q[6].fq[2][TW-1:0], pay_q[6].ly[0], pay_q[6].ly[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      pay_q[k] <= pay_d[k];
    end
  end

  // rescale to Q2.16 and saturate
  always_comb begin
    r_ext = RW'($signed(pay_q[NS-1].r));
    r_scl = (r_ext >>> SH_R) <<< SH_L;
    if (r_scl > SAT_MAX) begin
      r_sat = SAT_MAX[OUT_W-1:0];
    end else if (r_scl < SAT_MIN) begin
      r_sat = SAT_MIN[OUT_W-1:0];
    end else begin
      r_sat = r_scl[OUT_W-1:0];
    end
  end

  // result queue and credits
  assign out_push = vld_q[NS-1] && (pay_q[NS-1].kind == KIND_EVAL);
  assign empty_o  = (out_cnt_q == '0);
  assign out_pop  = pop_i && !empty_o;

  always_comb begin
    out_cnt_d = out_cnt_q + CNT_W'(out_push) - CNT_W'(out_pop);
    credit_d  = credit_q + CNT_W'(issue_eval) - CNT_W'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wptr_q <= '0;
      out_rptr_q <= '0;
      out_cnt_q  <= '0;
      credit_q   <= '0;
    end else begin
      if (out_push) begin
        out_wptr_q <= out_wptr_q + OPTR_W'(1);
      end
      if (out_pop) begin
        out_rptr_q <= out_rptr_q + OPTR_W'(1);
      end
      out_cnt_q <= out_cnt_d;
      credit_q  <= credit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[out_wptr_q] <= r_sat;
    end
  end

  assign noise_value_o     = $signed(out_mem_q[out_rptr_q]);
  assign stat_o.credits    = credit_q;
  assign stat_o.out_count  = out_cnt_q;

endmodule

// File: design/perlin_noise_3d_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_3d_eval: 3D improved Perlin noise evaluator
// Fixed-point gradient noise with a loadable 256-entry permutation table.
// ----------------------------------------------------------------------------
// Takes one word per cycle, loads and evaluations alike, while the front
// queue is not full; an evaluation waits at the head of that queue until
// the result queue has room. A word passes through the front queue, then
// the back pipeline, whose permutation table is held in seven dual-read
// RAM copies so all fourteen hash lookups of a sample fit in
// three stages. A load updates every copy in program order, so evaluations
// see exactly the loads pushed before them. There is no clearing pass:
// sampling table entries that were never loaded gives an unspecified value.
// Offsets may be written only while the block is idle.
module perlin_noise_3d_eval #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 kind_i,
  input  logic [pnz_pkg::IDX_W-1:0]            table_index_i,
  input  logic [pnz_pkg::IDX_W-1:0]            table_value_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]   x_coord_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]   y_coord_i,
  input  logic signed [pnz_pkg::COORD_W-1:0]   z_coord_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [pnz_pkg::OUT_W-1:0]     noise_value_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pnz_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pnz_pkg::OFF_W-1:0]            cfg_data_i
);
  import pnz_pkg::*;

  logic [OFF_W-1:0]          offset_x_q, offset_y_q, offset_z_q;
  logic                      cfg_wr;
  logic                      item_valid, item_ready;
  kind_e                     item_kind;
  logic [IDX_W-1:0]          item_tidx, item_tval;
  cell_t                     item_cell;
  logic [2:0][FRAC_BITS-1:0] item_frac;
  back_stat_t                back_stat;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
      offset_z_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET_X: offset_x_q <= cfg_data_i;
        CFG_OFFSET_Y: offset_y_q <= cfg_data_i;
        CFG_OFFSET_Z: offset_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pnz_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .kind_i        (kind_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .z_coord_i     (z_coord_i),
    .offset_x_i    (offset_x_q),
    .offset_y_i    (offset_y_q),
    .offset_z_i    (offset_z_q),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_kind_o   (item_kind),
    .item_tidx_o   (item_tidx),
    .item_tval_o   (item_tval),
    .item_cell_o   (item_cell),
    .item_frac_o   (item_frac)
  );

  pnz_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_kind_i   (item_kind),
    .item_tidx_i   (item_tidx),
    .item_tval_i   (item_tval),
    .item_cell_i   (item_cell),
    .item_frac_i   (item_frac),
    .empty_o       (empty),
    .pop_i         (pop),
    .noise_value_o (noise_value_o),
    .stat_o        (back_stat)
  );

  // offset write lands in its register
  a_cfg_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (cfg_index_i == CFG_OFFSET_X) |=> offset_x_q == $past(cfg_data_i))
    else $error("offset_x write lost");

  // queued results never exceed outstanding evaluations
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.out_count <= back_stat.credits)
    else $error("result queue exceeds credits");

  // credits bound the result queue
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.credits <= CNT_W'(OUT_DEPTH))
    else $error("credit overflow");

  // empty flag tracks the result count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty == (back_stat.out_count == '0))
    else $error("empty flag mismatch");

endmodule
